// ===== src/gbn_pkg.sv =====
package gbn_pkg;

	localparam int SEQ_MAX = 7;
	localparam int NSEQ    = SEQ_MAX + 1;
	localparam int SEQ_W   = 3;
	localparam int TMR_W   = 16;
	localparam int PAY_W   = 32;
	localparam int TIDX_W  = $clog2(NSEQ + 1);

	localparam logic [1:0] OP_PKT  = 2'd0;
	localparam logic [1:0] OP_RX   = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [1:0] RX_DATA = 2'd0;
	localparam logic [1:0] RX_ACK  = 2'd1;

	localparam logic [1:0] OUT_DATA   = 2'd0;
	localparam logic [1:0] OUT_ACK    = 2'd1;
	localparam logic [1:0] OUT_DELIV  = 2'd2;
	localparam logic [1:0] OUT_REFUSE = 2'd3;

	localparam logic [7:0] REG_FRAME_TMO = 8'd0;
	localparam logic [7:0] REG_ACK_TMO   = 8'd1;

	localparam logic [TMR_W-1:0] FRAME_TMO_RST = TMR_W'(1000);
	localparam logic [TMR_W-1:0] ACK_TMO_RST   = TMR_W'(500);

	typedef struct packed {
		logic [1:0]       op;
		logic [PAY_W-1:0] payload;
		logic [1:0]       rx_kind;
		logic [SEQ_W-1:0] rx_seq;
		logic [SEQ_W-1:0] rx_ack;
	} item_t;

	typedef struct packed {
		logic [1:0]       out_kind;
		logic [SEQ_W-1:0] out_seq;
		logic [SEQ_W-1:0] out_ack;
		logic [PAY_W-1:0] out_payload;
		logic             last;
	} result_t;

	typedef struct packed {
		logic             frame_load;
		logic             frame_clear;
		logic             frame_dec;
		logic [SEQ_W-1:0] idx;
		logic             ack_load;
		logic             ack_clear;
		logic             ack_dec;
	} tmr_cmd_t;

	typedef struct packed {
		logic expired;
		logic ack_idle;
	} tmr_stat_t;

	typedef struct packed {
		logic             we;
		logic             re;
		logic [SEQ_W-1:0] addr;
		logic [PAY_W-1:0] wdata;
	} st_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REFUSE,
		ST_SEND,
		ST_RX,
		ST_REL,
		ST_TICK,
		ST_TEVAL,
		ST_RD,
		ST_RESEND,
		ST_ACK
	} state_t;

	function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
		return (s == SEQ_W'(SEQ_MAX)) ? '0 : s + 1'b1;
	endfunction

	// True when b lies in the circular range [a, c).
	function automatic logic in_window(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b,
			input logic [SEQ_W-1:0] c);
		return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
	endfunction

	function automatic logic [TMR_W-1:0] nonzero(input logic [TMR_W-1:0] t);
		return (t == '0) ? TMR_W'(1) : t;
	endfunction

endpackage

// ===== src/gbn_store.sv =====
module gbn_store import gbn_pkg::*; (
	input  logic             clk,
	input  st_req_t          req,
	output logic [PAY_W-1:0] rdata
);

	logic [PAY_W-1:0] mem_q [NSEQ];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.addr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem_q[req.addr];
		end
	end

endmodule

// ===== src/gbn_timers.sv =====
module gbn_timers import gbn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  tmr_cmd_t         cmd,
	input  logic [TMR_W-1:0] frame_tmo,
	input  logic [TMR_W-1:0] ack_tmo,
	output tmr_stat_t        stat
);

	logic [TMR_W-1:0] frame_tmr_q [NSEQ];
	logic [TMR_W-1:0] ack_tmr_q;
	logic [TMR_W-1:0] dec_in;
	logic [TMR_W-1:0] dec_out;

	// One decrementer serves every timer; the sequencer picks one per cycle.
	always_comb begin
		dec_in       = cmd.ack_dec ? ack_tmr_q : frame_tmr_q[cmd.idx];
		dec_out      = (dec_in == '0) ? '0 : dec_in - 1'b1;
		stat.expired = (dec_in == TMR_W'(1));
		stat.ack_idle = (ack_tmr_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSEQ; i++) begin
				frame_tmr_q[i] <= '0;
			end
			ack_tmr_q <= '0;
		end else begin
			if (cmd.frame_load) begin
				frame_tmr_q[cmd.idx] <= nonzero(frame_tmo);
			end else if (cmd.frame_clear) begin
				frame_tmr_q[cmd.idx] <= '0;
			end else if (cmd.frame_dec) begin
				frame_tmr_q[cmd.idx] <= dec_out;
			end
			if (cmd.ack_load) begin
				ack_tmr_q <= nonzero(ack_tmo);
			end else if (cmd.ack_clear) begin
				ack_tmr_q <= '0;
			end else if (cmd.ack_dec) begin
				ack_tmr_q <= dec_out;
			end
		end
	end

endmodule

// ===== src/gbn_ctrl.sv =====
module gbn_ctrl import gbn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            item,
	input  logic             item_take,
	input  logic             room,
	input  tmr_stat_t        tstat,
	input  logic [PAY_W-1:0] srdata,
	output logic             busy,
	output logic             emit,
	output result_t          res,
	output tmr_cmd_t         tcmd,
	output st_req_t          sreq
);

	state_t            state_q, state_d;
	item_t             item_q;
	logic [SEQ_W-1:0]  nts_q, oldest_q, erx_q, cnt_q, rs_q;
	logic [TIDX_W-1:0] tidx_q;
	logic              fexp_q, aexp_q;

	logic [SEQ_W-1:0] ackn;
	logic             rx_ok, deliver, rel_go, last_rs, tick_ack;

	always_comb begin
		ackn     = (erx_q == '0) ? SEQ_W'(SEQ_MAX) : erx_q - 1'b1;
		rx_ok    = (item_q.rx_kind == RX_DATA) || (item_q.rx_kind == RX_ACK);
		deliver  = (item_q.rx_kind == RX_DATA) && (item_q.rx_seq == erx_q);
		rel_go   = (item_q.rx_ack <= SEQ_W'(SEQ_MAX)) && (cnt_q != '0)
			&& in_window(oldest_q, item_q.rx_ack, nts_q);
		last_rs  = (rs_q == cnt_q - 1'b1);
		tick_ack = (tidx_q == TIDX_W'(NSEQ));
		busy     = (state_q != ST_IDLE);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_take) begin
					case (item.op)
						OP_PKT:  state_d = (cnt_q >= SEQ_W'(SEQ_MAX)) ? ST_REFUSE : ST_SEND;
						OP_RX:   state_d = ST_RX;
						OP_TICK: state_d = ST_TICK;
						default: state_d = ST_TEVAL;
					endcase
				end
			end
			ST_REFUSE, ST_SEND, ST_ACK: begin
				if (room) state_d = ST_IDLE;
			end
			ST_RX: begin
				if (!rx_ok) begin
					state_d = ST_IDLE;
				end else if (!deliver || room) begin
					state_d = ST_REL;
				end
			end
			ST_REL: begin
				if (!rel_go) state_d = ST_IDLE;
			end
			ST_TICK: begin
				if (tick_ack) state_d = ST_TEVAL;
			end
			ST_TEVAL: begin
				if (fexp_q && cnt_q != '0) begin
					state_d = ST_RD;
				end else begin
					state_d = aexp_q ? ST_ACK : ST_IDLE;
				end
			end
			ST_RD: state_d = ST_RESEND;
			ST_RESEND: begin
				if (room) begin
					if (last_rs) begin
						state_d = aexp_q ? ST_ACK : ST_IDLE;
					end else begin
						state_d = ST_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		res  = '0;
		tcmd = '0;
		sreq = '0;
		unique case (state_q)
			ST_REFUSE: begin
				emit         = room;
				res.out_kind = OUT_REFUSE;
				res.last     = 1'b1;
			end
			ST_SEND: begin
				emit            = room;
				res.out_kind    = OUT_DATA;
				res.out_seq     = nts_q;
				res.out_ack     = ackn;
				res.out_payload = item_q.payload;
				res.last        = 1'b1;
				sreq.we         = room;
				sreq.addr       = nts_q;
				sreq.wdata      = item_q.payload;
				tcmd.frame_load = room;
				tcmd.idx        = nts_q;
				tcmd.ack_clear  = room;
			end
			ST_RX: begin
				if (rx_ok && deliver) begin
					emit            = room;
					res.out_kind    = OUT_DELIV;
					res.out_payload = item_q.payload;
					res.last        = 1'b1;
					tcmd.ack_load   = room && tstat.ack_idle;
				end
			end
			ST_REL: begin
				tcmd.frame_clear = rel_go;
				tcmd.idx         = oldest_q;
			end
			ST_TICK: begin
				tcmd.frame_dec = !tick_ack;
				tcmd.ack_dec   = tick_ack;
				tcmd.idx       = tidx_q[SEQ_W-1:0];
			end
			ST_RD: begin
				sreq.re   = 1'b1;
				sreq.addr = nts_q;
			end
			ST_RESEND: begin
				emit            = room;
				res.out_kind    = OUT_DATA;
				res.out_seq     = nts_q;
				res.out_ack     = ackn;
				res.out_payload = srdata;
				res.last        = last_rs && !aexp_q;
				tcmd.frame_load = room;
				tcmd.idx        = nts_q;
				tcmd.ack_clear  = room;
			end
			ST_ACK: begin
				emit           = room;
				res.out_kind   = OUT_ACK;
				res.out_seq    = nts_q;
				res.out_ack    = ackn;
				res.last       = 1'b1;
				tcmd.ack_clear = room;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_take) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			nts_q    <= '0;
			oldest_q <= '0;
			erx_q    <= '0;
			cnt_q    <= '0;
			rs_q     <= '0;
			tidx_q   <= '0;
			fexp_q   <= 1'b0;
			aexp_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					tidx_q <= '0;
					fexp_q <= 1'b0;
					aexp_q <= 1'b0;
				end
				ST_SEND: begin
					if (room) begin
						nts_q <= seq_inc(nts_q);
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RX: begin
					if (rx_ok && deliver && room) erx_q <= seq_inc(erx_q);
				end
				ST_REL: begin
					if (rel_go) begin
						cnt_q    <= cnt_q - 1'b1;
						oldest_q <= seq_inc(oldest_q);
					end
				end
				ST_TICK: begin
					tidx_q <= tidx_q + 1'b1;
					if (tick_ack) begin
						aexp_q <= tstat.expired;
					end else if (tstat.expired) begin
						fexp_q <= 1'b1;
					end
				end
				ST_TEVAL: begin
					// Go back to the oldest unacknowledged frame.
					if (fexp_q) begin
						nts_q <= oldest_q;
						rs_q  <= '0;
					end
				end
				ST_RESEND: begin
					if (room) begin
						nts_q <= seq_inc(nts_q);
						rs_q  <= rs_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== src/go_back_n_link_endpoint.sv =====
// Go-Back-N link endpoint with piggybacked acknowledgements.
// Input channel (item_valid, item_stall, item): each transaction is a packet
// from the upper layer, a received frame, or one timer tick. item_stall stays
// high while an item is being worked on; one item is handled at a time.
// Output channel (result_valid, result_stall, result): zero to eight results
// per item, the final one flagged by last. A registered output stage holds a
// result while the receiver stalls; the sequencer then waits on it.
// Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 is the
// frame timeout, index 1 the ack timeout; ready is always high.
// Sequence: a packet or refusal is sent from its own state; a received frame
// is delivered if in order, then each released frame (up to 7) is cleared in
// turn. A tick scans the eight frame timers and the ack timer through one
// shared decrementer, evaluates them, on a frame timeout resends each frame
// (read port of the packet store, then send) and may send a lone ack frame.
// Output stalls lengthen each of these steps.
// Reset clears all sequence state and timers and restores the default
// timeouts (1000 and 500 ticks); the packet store is not cleared.
module go_back_n_link_endpoint import gbn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_index,
	input  logic [TMR_W-1:0] cfg_data
);

	logic [TMR_W-1:0] frame_tmo_q, ack_tmo_q;
	logic             res_valid_q;
	result_t          res_q;
	logic             busy, emit, room, item_take;
	result_t          res;
	tmr_cmd_t         tcmd;
	tmr_stat_t        tstat;
	st_req_t          sreq;
	logic [PAY_W-1:0] srdata;

	assign cfg_ready    = 1'b1;
	assign item_stall   = busy;
	assign item_take    = item_valid && !busy;
	assign room         = !res_valid_q || !result_stall;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_tmo_q <= FRAME_TMO_RST;
			ack_tmo_q   <= ACK_TMO_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_TMO: frame_tmo_q <= cfg_data;
				REG_ACK_TMO:   ack_tmo_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res;
		end
	end

	gbn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.item_take (item_take),
		.room      (room),
		.tstat     (tstat),
		.srdata    (srdata),
		.busy      (busy),
		.emit      (emit),
		.res       (res),
		.tcmd      (tcmd),
		.sreq      (sreq)
	);

	gbn_timers u_timers (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (tcmd),
		.frame_tmo (frame_tmo_q),
		.ack_tmo   (ack_tmo_q),
		.stat      (tstat)
	);

	gbn_store u_store (
		.clk   (clk),
		.req   (sreq),
		.rdata (srdata)
	);

endmodule

// ===== src/gbn_checker.sv =====
module gbn_checker import gbn_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input result_t          result
);

	// A held result must not change until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// The endpoint works on one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("accepted an item while another was in progress");

	// A lone ack frame and a refusal always close out their item.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.out_kind == OUT_ACK || result.out_kind == OUT_REFUSE)
		|-> result.last)
		else $error("ack frame or refusal not flagged last");

	// Delivered and refused results carry no sequence or ack numbers.
	a_no_numbers: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.out_kind == OUT_DELIV || result.out_kind == OUT_REFUSE)
		|-> result.out_seq == '0 && result.out_ack == '0)
		else $error("nonzero numbers on a delivered or refused result");

endmodule

bind go_back_n_link_endpoint gbn_checker u_gbn_checker (.*);
